@@ rtl/core/ftb_pkg.sv @@
// Shared types, constants and tables for the fractal tree branch generator.
// Used by every module under rtl/core; depends on nothing else.
package ftb_pkg;

  localparam int COORD_BITS = 16;
  localparam int ANGLE_BITS = 16;
  localparam int COORD_FRAC = COORD_BITS - 3;
  localparam int LEN_W      = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 8;

  localparam int ROT_STEPS  = 20;
  localparam int STEP_W     = $clog2(ROT_STEPS);
  localparam int CORDIC_W   = 32;

  // Length times Q1.30 trig value, then the rounding shift down to the coordinate grid.
  localparam int PROD_W     = LEN_W + 1 + CORDIC_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int RND_SH     = 44 - COORD_FRAC;

  localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 32'sd652032874;

  localparam logic [CFG_ADDR_W-1:0] REG_LEFT_ANGLE  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_ANGLE = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_LEFT_SCALE  = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_SCALE = CFG_ADDR_W'(3);

  localparam logic [CFG_W-1:0] RST_ANGLE_OFFSET = 16'd3641;
  localparam logic [CFG_W-1:0] RST_SCALE        = 16'd22938;

  // atan(2^-i) in units of 2^32 per turn.
  localparam logic [CORDIC_W-1:0] ATAN_TAB [ROT_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2607,     32'd1303
  };

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
    logic                       flip;
  } lane_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] base_x;
    logic signed [COORD_BITS-1:0] base_y;
    logic [ANGLE_BITS-1:0]        left_heading;
    logic [ANGLE_BITS-1:0]        right_heading;
    logic [LEN_W-1:0]             left_length;
    logic [LEN_W-1:0]             right_length;
    logic                         sat;
    lane_t                        left;
    lane_t                        right;
  } item_t;

endpackage

@@ rtl/core/fractal_tree_branch_generator_top.sv @@
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  parent end point, heading, length
// out      output     out_valid/out_stall  left and right child, saturated flag
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data (four registers)
//
// One parent segment per clock while out_stall is low; a result passes 23
// registers on its way to the outputs: one front cell, twenty CORDIC
// rotation cells and two placement stages.
// Each stage moves on when the next one is empty or moving, so bubbles are
// squeezed out and a stalled result only holds back the stages behind it.
// rst_n clears all stage valids and loads the register defaults; cfg_ready is always high.
// Top level: config registers and the cell chain. Depends on ftb_pkg, ftb_prep,
// ftb_rot_cell and ftb_place.
module fractal_tree_branch_generator_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [ftb_pkg::COORD_BITS-1:0] in_parent_end_x,
  input  logic signed [ftb_pkg::COORD_BITS-1:0] in_parent_end_y,
  input  logic [ftb_pkg::ANGLE_BITS-1:0]        in_parent_heading,
  input  logic [ftb_pkg::LEN_W-1:0]             in_parent_length,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [ftb_pkg::COORD_BITS-1:0] out_left_end_x,
  output logic signed [ftb_pkg::COORD_BITS-1:0] out_left_end_y,
  output logic [ftb_pkg::ANGLE_BITS-1:0]        out_left_heading,
  output logic [ftb_pkg::LEN_W-1:0]             out_left_length,
  output logic signed [ftb_pkg::COORD_BITS-1:0] out_right_end_x,
  output logic signed [ftb_pkg::COORD_BITS-1:0] out_right_end_y,
  output logic [ftb_pkg::ANGLE_BITS-1:0]        out_right_heading,
  output logic [ftb_pkg::LEN_W-1:0]             out_right_length,
  output logic                                  out_saturated,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ftb_pkg::CFG_ADDR_W-1:0]        cfg_index,
  input  logic [ftb_pkg::CFG_W-1:0]             cfg_data
);
  import ftb_pkg::*;

  localparam logic signed [COORD_BITS-1:0] C_RAIL_HI = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] C_RAIL_LO = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic [CFG_W-1:0] left_angle_r;
  logic [CFG_W-1:0] right_angle_r;
  logic [CFG_W-1:0] left_scale_r;
  logic [CFG_W-1:0] right_scale_r;

  logic  prep_ready;
  logic  chain_valid [ROT_STEPS+1];
  logic  chain_ready [ROT_STEPS+1];
  item_t chain_item  [ROT_STEPS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_angle_r  <= RST_ANGLE_OFFSET;
      right_angle_r <= RST_ANGLE_OFFSET;
      left_scale_r  <= RST_SCALE;
      right_scale_r <= RST_SCALE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEFT_ANGLE:  left_angle_r  <= cfg_data;
        REG_RIGHT_ANGLE: right_angle_r <= cfg_data;
        REG_LEFT_SCALE:  left_scale_r  <= cfg_data;
        REG_RIGHT_SCALE: right_scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = !prep_ready;

  ftb_prep u_prep (
    .clk                (clk),
    .rst_n              (rst_n),
    .up_valid           (in_valid),
    .up_ready           (prep_ready),
    .parent_end_x       (in_parent_end_x),
    .parent_end_y       (in_parent_end_y),
    .parent_heading     (in_parent_heading),
    .parent_length      (in_parent_length),
    .left_angle_offset  (left_angle_r),
    .right_angle_offset (right_angle_r),
    .left_scale         (left_scale_r),
    .right_scale        (right_scale_r),
    .dn_valid           (chain_valid[0]),
    .dn_ready           (chain_ready[0]),
    .dn_item            (chain_item[0])
  );

  for (genvar i = 0; i < ROT_STEPS; i++) begin : g_rot
    ftb_rot_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .step     (STEP_W'(i)),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_item  (chain_item[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_item  (chain_item[i+1])
    );
  end

  ftb_place u_place (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (chain_valid[ROT_STEPS]),
    .up_ready      (chain_ready[ROT_STEPS]),
    .up_item       (chain_item[ROT_STEPS]),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .left_end_x    (out_left_end_x),
    .left_end_y    (out_left_end_y),
    .left_heading  (out_left_heading),
    .left_length   (out_left_length),
    .right_end_x   (out_right_end_x),
    .right_end_y   (out_right_end_y),
    .right_heading (out_right_heading),
    .right_length  (out_right_length),
    .saturated     (out_saturated)
  );

  // The front cell refuses a transfer only while it holds an item itself.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> chain_valid[0])
    else $error("input stalled with an empty front cell");

  // A raised flag must be explained by a clipped length or a coordinate at a rail.
  a_sat_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_left_length == '1 || out_right_length == '1 ||
       out_left_end_x == C_RAIL_HI || out_left_end_x == C_RAIL_LO ||
       out_left_end_y == C_RAIL_HI || out_left_end_y == C_RAIL_LO ||
       out_right_end_x == C_RAIL_HI || out_right_end_x == C_RAIL_LO ||
       out_right_end_y == C_RAIL_HI || out_right_end_y == C_RAIL_LO))
    else $error("saturated flag without a clipped field");

  a_cfg_scale_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == REG_LEFT_SCALE) |=>
      (left_scale_r == $past(cfg_data)))
    else $error("left scale register did not take the write");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_left_end_x) &&
                                  $stable(out_right_length)))
    else $error("stalled result changed");

endmodule

@@ rtl/core/ftb_prep.sv @@
// Front cell: child headings, scaled lengths and the CORDIC start vectors.
// Depends on ftb_pkg.
module ftb_prep (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 up_valid,
  output logic                                 up_ready,
  input  logic signed [ftb_pkg::COORD_BITS-1:0] parent_end_x,
  input  logic signed [ftb_pkg::COORD_BITS-1:0] parent_end_y,
  input  logic [ftb_pkg::ANGLE_BITS-1:0]        parent_heading,
  input  logic [ftb_pkg::LEN_W-1:0]             parent_length,
  input  logic [ftb_pkg::CFG_W-1:0]             left_angle_offset,
  input  logic [ftb_pkg::CFG_W-1:0]             right_angle_offset,
  input  logic [ftb_pkg::CFG_W-1:0]             left_scale,
  input  logic [ftb_pkg::CFG_W-1:0]             right_scale,
  output logic                                 dn_valid,
  input  logic                                 dn_ready,
  output ftb_pkg::item_t                       dn_item
);
  import ftb_pkg::*;

  logic                  valid_r;
  item_t                 item_r;
  item_t                 item_nxt;
  logic [ANGLE_BITS-1:0] lh;
  logic [ANGLE_BITS-1:0] rh;
  logic [LEN_W-1:0]      llen;
  logic [LEN_W-1:0]      rlen;
  logic                  lsat;
  logic                  rsat;

  function automatic void scale_len(input logic [LEN_W-1:0] plen,
                                    input logic [CFG_W-1:0] scale,
                                    output logic [LEN_W-1:0] len,
                                    output logic clip);
    logic [LEN_W+CFG_W:0] prod;
    logic [LEN_W+CFG_W-15:0] q;
    prod = (LEN_W + CFG_W + 1)'(plen) * (LEN_W + CFG_W + 1)'(scale)
           + (LEN_W + CFG_W + 1)'(16384);
    q    = prod[LEN_W+CFG_W:15];
    clip = |q[LEN_W+CFG_W-15:LEN_W];
    len  = clip ? '1 : q[LEN_W-1:0];
  endfunction

  // Quadrants two and three are folded by half a turn and negated at the end.
  function automatic lane_t start_lane(input logic [ANGLE_BITS-1:0] hd);
    logic [CORDIC_W-1:0] a;
    lane_t l;
    a      = {hd, {(CORDIC_W - ANGLE_BITS){1'b0}}};
    l.flip = a[CORDIC_W-1] ^ a[CORDIC_W-2];
    l.z    = $signed({a[CORDIC_W-1] ^ l.flip, a[CORDIC_W-2:0]});
    l.x    = GAIN_Q30;
    l.y    = '0;
    return l;
  endfunction

  always_comb begin
    lh = parent_heading - ANGLE_BITS'(left_angle_offset);
    rh = parent_heading + ANGLE_BITS'(right_angle_offset);
    scale_len(parent_length, left_scale, llen, lsat);
    scale_len(parent_length, right_scale, rlen, rsat);
    item_nxt.base_x        = parent_end_x;
    item_nxt.base_y        = parent_end_y;
    item_nxt.left_heading  = lh;
    item_nxt.right_heading = rh;
    item_nxt.left_length   = llen;
    item_nxt.right_length  = rlen;
    item_nxt.sat           = lsat | rsat;
    item_nxt.left          = start_lane(lh);
    item_nxt.right         = start_lane(rh);
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

@@ rtl/core/ftb_rot_cell.sv @@
// One CORDIC rotation cell for both children; a row of these forms the rotator.
// Depends on ftb_pkg.
module ftb_rot_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ftb_pkg::STEP_W-1:0]   step,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  ftb_pkg::item_t               up_item,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output ftb_pkg::item_t               dn_item
);
  import ftb_pkg::*;

  logic  valid_r;
  item_t item_r;
  item_t item_nxt;

  function automatic lane_t rotate(input lane_t l, input logic [STEP_W-1:0] s);
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [CORDIC_W-1:0] da;
    lane_t r;
    dx = l.y >>> s;
    dy = l.x >>> s;
    da = $signed(ATAN_TAB[s]);
    r  = l;
    if (!l.z[CORDIC_W-1]) begin
      r.x = l.x - dx;
      r.y = l.y + dy;
      r.z = l.z - da;
    end else begin
      r.x = l.x + dx;
      r.y = l.y - dy;
      r.z = l.z + da;
    end
    return r;
  endfunction

  always_comb begin
    item_nxt       = up_item;
    item_nxt.left  = rotate(up_item.left, step);
    item_nxt.right = rotate(up_item.right, step);
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

@@ rtl/core/ftb_place.sv @@
// End point placement: length times cos/sin, rounding, offset add and clipping.
// Two register stages, the second being the result register. Depends on ftb_pkg.
module ftb_place (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  up_valid,
  output logic                                  up_ready,
  input  ftb_pkg::item_t                        up_item,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [ftb_pkg::COORD_BITS-1:0] left_end_x,
  output logic signed [ftb_pkg::COORD_BITS-1:0] left_end_y,
  output logic [ftb_pkg::ANGLE_BITS-1:0]        left_heading,
  output logic [ftb_pkg::LEN_W-1:0]             left_length,
  output logic signed [ftb_pkg::COORD_BITS-1:0] right_end_x,
  output logic signed [ftb_pkg::COORD_BITS-1:0] right_end_y,
  output logic [ftb_pkg::ANGLE_BITS-1:0]        right_heading,
  output logic [ftb_pkg::LEN_W-1:0]             right_length,
  output logic                                  saturated
);
  import ftb_pkg::*;

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(64'sd1 <<< (RND_SH - 1));
  localparam logic signed [SUM_W-1:0]  C_HI     = SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0]  C_LO     = -C_HI - SUM_W'(1);

  // Product stage
  logic                         mul_valid_r;
  logic                         mul_ready;
  logic signed [COORD_BITS-1:0] base_x_r;
  logic signed [COORD_BITS-1:0] base_y_r;
  logic [ANGLE_BITS-1:0]        lh_r;
  logic [ANGLE_BITS-1:0]        rh_r;
  logic [LEN_W-1:0]             llen_r;
  logic [LEN_W-1:0]             rlen_r;
  logic                         sat_r;
  logic signed [PROD_W-1:0]     plx_r;
  logic signed [PROD_W-1:0]     ply_r;
  logic signed [PROD_W-1:0]     prx_r;
  logic signed [PROD_W-1:0]     pry_r;

  // Result stage
  logic                         res_valid_r;
  logic                         res_ready;
  logic signed [COORD_BITS-1:0] lx_nxt;
  logic signed [COORD_BITS-1:0] ly_nxt;
  logic signed [COORD_BITS-1:0] rx_nxt;
  logic signed [COORD_BITS-1:0] ry_nxt;
  logic                         clip_lx;
  logic                         clip_ly;
  logic                         clip_rx;
  logic                         clip_ry;

  function automatic logic signed [PROD_W-1:0] mul_trig(input logic [LEN_W-1:0] len,
                                                        input logic signed [CORDIC_W-1:0] v,
                                                        input logic flip);
    logic signed [CORDIC_W-1:0] t;
    logic signed [LEN_W:0]      l;
    t = flip ? -v : v;
    l = $signed({1'b0, len});
    return PROD_W'(l) * PROD_W'(t);
  endfunction

  function automatic void place(input logic signed [COORD_BITS-1:0] base,
                                input logic signed [PROD_W-1:0] p,
                                output logic signed [COORD_BITS-1:0] r,
                                output logic clip);
    logic signed [PROD_W-1:0] off;
    logic signed [SUM_W-1:0]  s;
    off = (p + RND_HALF) >>> RND_SH;
    s   = SUM_W'(base) + SUM_W'(off);
    if (s > C_HI) begin
      r    = C_HI[COORD_BITS-1:0];
      clip = 1'b1;
    end else if (s < C_LO) begin
      r    = C_LO[COORD_BITS-1:0];
      clip = 1'b1;
    end else begin
      r    = s[COORD_BITS-1:0];
      clip = 1'b0;
    end
  endfunction

  assign res_ready = !res_valid_r || !out_stall;
  assign mul_ready = !mul_valid_r || res_ready;
  assign up_ready  = mul_ready;
  assign out_valid = res_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (mul_ready) begin
      mul_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready && up_valid) begin
      base_x_r <= up_item.base_x;
      base_y_r <= up_item.base_y;
      lh_r     <= up_item.left_heading;
      rh_r     <= up_item.right_heading;
      llen_r   <= up_item.left_length;
      rlen_r   <= up_item.right_length;
      sat_r    <= up_item.sat;
      plx_r    <= mul_trig(up_item.left_length, up_item.left.x, up_item.left.flip);
      ply_r    <= mul_trig(up_item.left_length, up_item.left.y, up_item.left.flip);
      prx_r    <= mul_trig(up_item.right_length, up_item.right.x, up_item.right.flip);
      pry_r    <= mul_trig(up_item.right_length, up_item.right.y, up_item.right.flip);
    end
  end

  always_comb begin
    place(base_x_r, plx_r, lx_nxt, clip_lx);
    place(base_y_r, ply_r, ly_nxt, clip_ly);
    place(base_x_r, prx_r, rx_nxt, clip_rx);
    place(base_y_r, pry_r, ry_nxt, clip_ry);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_ready) begin
      res_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && mul_valid_r) begin
      left_end_x    <= lx_nxt;
      left_end_y    <= ly_nxt;
      left_heading  <= lh_r;
      left_length   <= llen_r;
      right_end_x   <= rx_nxt;
      right_end_y   <= ry_nxt;
      right_heading <= rh_r;
      right_length  <= rlen_r;
      saturated     <= sat_r | clip_lx | clip_ly | clip_rx | clip_ry;
    end
  end

endmodule
